// ===== src/vsb_pkg.sv =====
// vsb_pkg: shared types, constants and saturation helper for the skinning blend unit
// no dependencies
`default_nettype none

package vsb_pkg;

    localparam int COORD_W        = 32;
    localparam int WORDS_PER_BONE = 12;
    localparam int BONE_IDX_W     = 8;
    localparam int ELEM_W         = 4;
    localparam int WEIGHT_W       = 16;

    localparam logic signed [COORD_W-1:0] ONE_Q16   = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    localparam logic [1:0] CFG_BONE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_COUNT = 2'd1;
    localparam logic [1:0] CFG_IDENTITY     = 2'd2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SKIN = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                  we;
        logic [BONE_IDX_W-1:0] bone;
        logic [ELEM_W-1:0]     elem;
        logic [COORD_W-1:0]    data;
    } t_load;

    typedef struct packed {
        logic signed [COORD_W-1:0] val;
        logic                      ov;
    } t_sat;

    function automatic t_sat sat_coord(input logic signed [63:0] v);
        t_sat r;
        if (v > 64'(COORD_MAX)) begin
            r.val = COORD_MAX;
            r.ov  = 1'b1;
        end else if (v < 64'(COORD_MIN)) begin
            r.val = COORD_MIN;
            r.ov  = 1'b1;
        end else begin
            r.val = v[COORD_W-1:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/vsb_lane.sv =====
// vsb_lane: one influence lane, bone matrix banks, transform and weight stages
// depends on vsb_pkg
`default_nettype none

module vsb_lane #(
    parameter int MAX_BONES = 256
) (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire                         i_identity,
    input  vsb_pkg::t_load              i_load,
    input  wire                         i_act,
    input  wire [vsb_pkg::BONE_IDX_W-1:0] i_bone,
    input  wire [vsb_pkg::WEIGHT_W-1:0] i_weight,
    input  wire signed [31:0]           i_pos [3],
    input  wire signed [31:0]           i_nrm [3],
    output logic signed [31:0]          o_tp [3],
    output logic signed [31:0]          o_tn [3],
    output logic                        o_ov
);
    localparam int BONE_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    // stage 1: bank read and operand capture
    logic [31:0]        r1_m [12];
    logic signed [31:0] r1_p [3];
    logic signed [31:0] r1_n [3];
    logic [15:0]        r1_w;
    logic               r1_act;

    genvar e;
    generate
        for (e = 0; e < vsb_pkg::WORDS_PER_BONE; e++) begin : g_bank
            logic [31:0] r_mem [MAX_BONES];
            always_ff @(posedge i_clk) begin
                if (i_load.we && i_load.elem == vsb_pkg::ELEM_W'(e)) begin
                    r_mem[i_load.bone[BONE_W-1:0]] <= i_load.data;
                end
                if (i_en) begin
                    r1_m[e] <= r_mem[i_bone[BONE_W-1:0]];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p   <= i_pos;
            r1_n   <= i_nrm;
            r1_w   <= i_weight;
            r1_act <= i_act;
        end
    end

    // stage 2: matrix products
    logic signed [31:0] n_m [12];
    logic signed [63:0] r2_pp [3][3];
    logic signed [63:0] r2_np [3][3];
    logic signed [31:0] r2_ofs [3];
    logic [15:0]        r2_w;
    logic               r2_act;

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            if (i_identity) begin
                n_m[k] = (k == 0 || k == 4 || k == 8) ? vsb_pkg::ONE_Q16 : 32'sd0;
            end else begin
                n_m[k] = $signed(r1_m[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r2_pp[c][r] <= 64'(r1_p[r]) * 64'(n_m[3*r+c]);
                    r2_np[c][r] <= 64'(r1_n[r]) * 64'(n_m[3*r+c]);
                end
                r2_ofs[c] <= n_m[9+c];
            end
            r2_w   <= r1_w;
            r2_act <= r1_act;
        end
    end

    // stage 3: transformed components
    logic signed [31:0] n_tp [3];
    logic signed [31:0] n_tn [3];
    logic               n_ov3;
    logic signed [31:0] r3_tp [3];
    logic signed [31:0] r3_tn [3];
    logic               r3_ov;
    logic [15:0]        r3_w;
    logic               r3_act;

    always_comb begin
        logic signed [63:0] sp;
        logic signed [63:0] sn;
        vsb_pkg::t_sat      s;
        n_ov3 = 1'b0;
        for (int c = 0; c < 3; c++) begin
            sp = 64'(r2_ofs[c]);
            sn = 64'sd0;
            for (int r = 0; r < 3; r++) begin
                s     = vsb_pkg::sat_coord(r2_pp[c][r] >>> 16);
                n_ov3 = n_ov3 | s.ov;
                sp    = sp + 64'(s.val);
                s     = vsb_pkg::sat_coord(r2_np[c][r] >>> 16);
                n_ov3 = n_ov3 | s.ov;
                sn    = sn + 64'(s.val);
            end
            s       = vsb_pkg::sat_coord(sp);
            n_ov3   = n_ov3 | s.ov;
            n_tp[c] = s.val;
            s       = vsb_pkg::sat_coord(sn);
            n_ov3   = n_ov3 | s.ov;
            n_tn[c] = s.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_tp  <= n_tp;
            r3_tn  <= n_tn;
            r3_ov  <= n_ov3;
            r3_w   <= r2_w;
            r3_act <= r2_act;
        end
    end

    // stage 4: weight products
    logic signed [48:0] r4_wp [3];
    logic signed [48:0] r4_wn [3];
    logic               r4_ov;
    logic               r4_act;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r4_wp[c] <= 49'(r3_tp[c]) * $signed({33'd0, r3_w});
                r4_wn[c] <= 49'(r3_tn[c]) * $signed({33'd0, r3_w});
            end
            r4_ov  <= r3_ov;
            r4_act <= r3_act;
        end
    end

    // stage 5: weighted terms, zero for a skipped influence
    logic signed [31:0] n_op [3];
    logic signed [31:0] n_on [3];
    logic               n_ov5;

    always_comb begin
        vsb_pkg::t_sat s;
        n_ov5 = r4_ov;
        for (int c = 0; c < 3; c++) begin
            s       = vsb_pkg::sat_coord(64'(r4_wp[c] >>> 15));
            n_ov5   = n_ov5 | s.ov;
            n_op[c] = r4_act ? s.val : 32'sd0;
            s       = vsb_pkg::sat_coord(64'(r4_wn[c] >>> 15));
            n_ov5   = n_ov5 | s.ov;
            n_on[c] = r4_act ? s.val : 32'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tp <= n_op;
            o_tn <= n_on;
            o_ov <= n_ov5 & r4_act;
        end
    end

endmodule

`default_nettype wire

// ===== src/vsb_merge.sv =====
// vsb_merge: sums lane terms, final saturation and the output register
// depends on vsb_pkg
`default_nettype none

module vsb_merge #(
    parameter int LANES = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_vld,
    input  wire                i_last,
    input  wire signed [31:0]  i_tp [LANES][3],
    input  wire signed [31:0]  i_tn [LANES][3],
    input  wire [LANES-1:0]    i_ov,
    output logic               o_vld,
    output logic signed [31:0] o_pos [3],
    output logic signed [31:0] o_nrm [3],
    output logic               o_last,
    output logic               o_ov
);
    logic signed [31:0] n_pos [3];
    logic signed [31:0] n_nrm [3];
    logic               n_ov;

    always_comb begin
        logic signed [63:0] ap;
        logic signed [63:0] an;
        vsb_pkg::t_sat      s;
        n_ov = |i_ov;
        for (int c = 0; c < 3; c++) begin
            ap = 64'sd0;
            an = 64'sd0;
            for (int j = 0; j < LANES; j++) begin
                ap = ap + 64'(i_tp[j][c]);
                an = an + 64'(i_tn[j][c]);
            end
            s        = vsb_pkg::sat_coord(ap);
            n_ov     = n_ov | s.ov;
            n_pos[c] = s.val;
            s        = vsb_pkg::sat_coord(an);
            n_ov     = n_ov | s.ov;
            n_nrm[c] = s.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pos  <= n_pos;
            o_nrm  <= n_nrm;
            o_last <= i_last;
            o_ov   <= n_ov;
        end
    end

endmodule

`default_nettype wire

// ===== src/vertex_skinning_blend_unit.sv =====
// Linear blend skinning unit: one beat per clock, either a bone matrix word load
// or a vertex. A vertex result passes through six register stages; one lane per
// influence, up to four, each holding its own copy of the bone matrix banks (twelve
// banks of MAX_BONES words, one per matrix element) so all influences read together.
// The pipeline advances as a whole and stalls only while a result waits.
// depends on vsb_pkg, vsb_lane, vsb_merge
`default_nettype none

module vertex_skinning_blend_unit #(
    parameter int MAX_BONES  = 256,
    parameter int INFLUENCES = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [1:0]          i_cfg_idx,
    input  wire [8:0]          i_cfg_data,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire                i_opcode,
    input  wire [11:0]         i_load_index,
    input  wire signed [31:0]  i_load_value,
    input  wire signed [31:0]  i_pos_x,
    input  wire signed [31:0]  i_pos_y,
    input  wire signed [31:0]  i_pos_z,
    input  wire signed [31:0]  i_nrm_x,
    input  wire signed [31:0]  i_nrm_y,
    input  wire signed [31:0]  i_nrm_z,
    input  wire [63:0]         i_weights_packed,
    input  wire [31:0]         i_bones_packed,
    input  wire                i_last_vertex,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_out_nrm_x,
    output logic signed [31:0] o_out_nrm_y,
    output logic signed [31:0] o_out_nrm_z,
    output logic               o_last_out,
    output logic               o_overflow
);
    localparam int LANES       = (INFLUENCES < 4) ? INFLUENCES : 4;
    localparam int STORE_DEPTH = MAX_BONES * vsb_pkg::WORDS_PER_BONE;

    logic [8:0] r_bone_count;
    logic [2:0] r_weight_count;
    logic       r_identity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_count   <= 9'd0;
            r_weight_count <= 3'd4;
            r_identity     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vsb_pkg::CFG_BONE_COUNT:   r_bone_count   <= i_cfg_data;
                vsb_pkg::CFG_WEIGHT_COUNT: r_weight_count <= i_cfg_data[2:0];
                vsb_pkg::CFG_IDENTITY:     r_identity     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic w_accept;
    logic w_skin;
    assign w_en     = !o_valid || i_ready;
    assign o_ready  = w_en;
    assign w_accept = i_valid && w_en;
    assign w_skin   = w_accept && (i_opcode == vsb_pkg::OP_SKIN);

    // load index split into bone and element: divide by twelve via reciprocal
    logic [23:0]     w_div_prod;
    logic [11:0]     w_rem;
    vsb_pkg::t_load  w_load;
    assign w_div_prod  = 24'(i_load_index) * 24'd2731;
    assign w_load.bone = w_div_prod[22:15];
    assign w_rem       = i_load_index - 12'(w_load.bone) * 12'd12;
    assign w_load.elem = w_rem[3:0];
    assign w_load.data = i_load_value;
    assign w_load.we   = w_accept && (i_opcode == vsb_pkg::OP_LOAD)
                         && (13'(i_load_index) < 13'(STORE_DEPTH));

    logic signed [31:0] w_pos [3];
    logic signed [31:0] w_nrm [3];
    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;
    assign w_nrm[0] = i_nrm_x;
    assign w_nrm[1] = i_nrm_y;
    assign w_nrm[2] = i_nrm_z;

    logic signed [31:0] w_tp [LANES][3];
    logic signed [31:0] w_tn [LANES][3];
    logic [LANES-1:0]   w_ov;

    genvar j;
    generate
        for (j = 0; j < LANES; j++) begin : g_lane
            logic [15:0] w_weight;
            logic [7:0]  w_bone;
            logic        w_act;
            assign w_weight = i_weights_packed[16*j +: 16];
            assign w_bone   = i_bones_packed[8*j +: 8];
            assign w_act    = (4'(j) < 4'(r_weight_count)) && (w_weight != 16'd0)
                              && (9'(w_bone) < r_bone_count)
                              && (10'(w_bone) < 10'(MAX_BONES));
            vsb_lane #(
                .MAX_BONES (MAX_BONES)
            ) u_lane (
                .i_clk      (i_clk),
                .i_en       (w_en),
                .i_identity (r_identity),
                .i_load     (w_load),
                .i_act      (w_act),
                .i_bone     (w_bone),
                .i_weight   (w_weight),
                .i_pos      (w_pos),
                .i_nrm      (w_nrm),
                .o_tp       (w_tp[j]),
                .o_tn       (w_tn[j]),
                .o_ov       (w_ov[j])
            );
        end
    endgenerate

    logic [4:0] r_vld;
    logic [4:0] r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 5'd0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], w_skin};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[3:0], i_last_vertex};
        end
    end

    logic signed [31:0] w_opos [3];
    logic signed [31:0] w_onrm [3];

    vsb_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld[4]),
        .i_last  (r_last[4]),
        .i_tp    (w_tp),
        .i_tn    (w_tn),
        .i_ov    (w_ov),
        .o_vld   (o_valid),
        .o_pos   (w_opos),
        .o_nrm   (w_onrm),
        .o_last  (o_last_out),
        .o_ov    (o_overflow)
    );

    assign o_out_pos_x = w_opos[0];
    assign o_out_pos_y = w_opos[1];
    assign o_out_pos_z = w_opos[2];
    assign o_out_nrm_x = w_onrm[0];
    assign o_out_nrm_y = w_onrm[1];
    assign o_out_nrm_z = w_onrm[2];

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_opcode == vsb_pkg::OP_LOAD) |=> !r_vld[0])
        else $error("load beat entered the result pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vld[4]))
        else $error("result without a vertex in the last lane stage");

endmodule

`default_nettype wire
